// ===== design/dpo_pkg.sv =====
// Shared types, constants and calendar functions for the date period overlap block.
`default_nettype none

package dpo_pkg;

    // Field widths of one date.
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;

    // Width of the overlap counter; the count saturates at its all-ones value.
    localparam int unsigned COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam int unsigned OUT_W = 16;

    // Gregorian cycle lengths in years.
    localparam int unsigned YEAR_CYCLE = 400;
    localparam int unsigned CENTURY    = 100;
    localparam int unsigned R400_W     = 9;

    // Calendar codes.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_SAT     = 2'd2;

    // Packed so that comparing two valid dates as numbers orders them in time.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    // Leap year from the year taken modulo 400.
    function automatic logic is_leap(input logic [R400_W-1:0] r400);
        logic century;
        century = (r400 == R400_W'(CENTURY)) || (r400 == R400_W'(2 * CENTURY))
               || (r400 == R400_W'(3 * CENTURY));
        return (r400[1:0] == 2'b00) && !century;
    endfunction

    // Length of a month; zero for a month code outside January to December.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (month) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== design/dpo_mod400.sv =====
// Iterative unit that reduces a year modulo 400 by shifted compare and subtract.
`default_nettype none

module dpo_mod400
    import dpo_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [YEAR_W-1:0] i_year,
    output logic                   o_done,
    output logic [R400_W-1:0]      o_rem
);

    // 400 shifted left by this much is the largest power-of-two multiple that fits the year.
    localparam logic [2:0]        TOP_SHIFT = 3'd5;
    localparam logic [YEAR_W-1:0] CYCLE_W   = YEAR_W'(YEAR_CYCLE);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [2:0]        r_step, n_step;
    logic [YEAR_W-1:0] r_rem, n_rem;
    logic [YEAR_W-1:0] sub;

    // One compare and subtract per cycle, largest multiple first.
    always_comb begin
        sub    = CYCLE_W << r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = TOP_SHIFT;
            n_rem  = i_year;
        end else if (r_busy) begin
            if (r_rem >= sub) begin
                n_rem = r_rem - sub;
            end
            if (r_step == 3'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[R400_W-1:0];

endmodule

`default_nettype wire

// ===== design/dpo_date_step.sv =====
// Calendar unit: checks a date and gives the following day.
`default_nettype none

module dpo_date_step
    import dpo_pkg::*;
(
    input  wire t_date              i_date,
    input  wire logic [R400_W-1:0]  i_r400,
    output logic                    o_date_ok,
    output t_date                   o_next,
    output logic [R400_W-1:0]       o_next_r400
);

    logic [DAY_W-1:0] dim;

    assign dim = month_days(i_date.month, is_leap(i_r400));

    // A month code outside the year gives a zero length and so fails here too.
    assign o_date_ok = (dim != '0) && (i_date.day != '0) && (i_date.day <= dim);

    // Advance by one day, rolling over month and year.
    always_comb begin
        o_next      = i_date;
        o_next_r400 = i_r400;
        if (i_date.day < dim) begin
            o_next.day = i_date.day + DAY_FIRST;
        end else begin
            o_next.day = DAY_FIRST;
            if (i_date.month < MONTH_DEC) begin
                o_next.month = i_date.month + MONTH_JAN;
            end else begin
                o_next.month = MONTH_JAN;
                o_next.year  = i_date.year + YEAR_W'(1);
                if (i_r400 == R400_W'(YEAR_CYCLE - 1)) begin
                    o_next_r400 = '0;
                end else begin
                    o_next_r400 = i_r400 + R400_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/date_period_overlap_days.sv =====
// Top level of the date period overlap counter: sequencer, date registers and result.
`default_nettype none

// Takes two date periods per item and returns the number of days from the later start
// up to, but not including, the earlier end, or zero when they do not overlap. Each
// of the four dates is first checked: its year is reduced modulo 400 by a six-step
// compare and subtract unit, then the calendar unit tests month and day. Any bad
// date ends the item at once with status 1 and a zero count. Otherwise the same
// calendar unit walks from the later start one day per cycle until it meets the
// earlier end or the counter reaches 2^COUNT_BITS - 1 (status 2), so the day walk
// sets most of the time that an item takes. One item is in work at a time: o_ready
// is high only while the block is idle, and the result holds on o_valid until taken.
module date_period_overlap_days
    import dpo_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [YEAR_W-1:0]  i_first_start_year,
    input  wire logic [MONTH_W-1:0] i_first_start_month,
    input  wire logic [DAY_W-1:0]   i_first_start_day,
    input  wire logic [YEAR_W-1:0]  i_first_end_year,
    input  wire logic [MONTH_W-1:0] i_first_end_month,
    input  wire logic [DAY_W-1:0]   i_first_end_day,
    input  wire logic [YEAR_W-1:0]  i_second_start_year,
    input  wire logic [MONTH_W-1:0] i_second_start_month,
    input  wire logic [DAY_W-1:0]   i_second_start_day,
    input  wire logic [YEAR_W-1:0]  i_second_end_year,
    input  wire logic [MONTH_W-1:0] i_second_end_month,
    input  wire logic [DAY_W-1:0]   i_second_end_day,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [OUT_W-1:0]        o_overlap_days,
    output logic [1:0]              o_status
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_START  = 7'b0000010,
        S_MOD    = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_SELECT = 7'b0010000,
        S_WALK   = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    // Date slots: period one start and end, then period two start and end.
    localparam logic [1:0] IDX_S1 = 2'd0;
    localparam logic [1:0] IDX_E1 = 2'd1;
    localparam logic [1:0] IDX_S2 = 2'd2;
    localparam logic [1:0] IDX_E2 = 2'd3;

    t_state                r_state, n_state;
    logic [1:0]            r_idx, n_idx;
    t_date                 r_dates [4];
    logic [R400_W-1:0]     r_r400  [4];
    t_date                 r_cur, n_cur;
    logic [R400_W-1:0]     r_cur400, n_cur400;
    t_date                 r_end, n_end;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [1:0]            r_status, n_status;

    logic                  accept_in;
    logic                  mod_done;
    logic [R400_W-1:0]     mod_rem;
    t_date                 step_date;
    logic [R400_W-1:0]     step_r400;
    logic                  step_ok;
    t_date                 step_next;
    logic [R400_W-1:0]     step_next_r400;
    logic                  s1_later, e1_earlier;
    logic [31:0]           count_wide;

    assign accept_in = i_valid && o_ready;

    // Year reduction unit, run once per date.
    dpo_mod400 u_mod400 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_year  (r_dates[r_idx].year),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // Calendar unit, shared by the date checks and the day walk.
    assign step_date = (r_state == S_WALK) ? r_cur : r_dates[r_idx];
    assign step_r400 = (r_state == S_WALK) ? r_cur400 : mod_rem;

    dpo_date_step u_date_step (
        .i_date      (step_date),
        .i_r400      (step_r400),
        .o_date_ok   (step_ok),
        .o_next      (step_next),
        .o_next_r400 (step_next_r400)
    );

    assign s1_later   = r_dates[IDX_S1] > r_dates[IDX_S2];
    assign e1_earlier = r_dates[IDX_E1] < r_dates[IDX_E2];

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_cur    = r_cur;
        n_cur400 = r_cur400;
        n_end    = r_end;
        n_count  = r_count;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    n_idx   = IDX_S1;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (mod_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!step_ok) begin
                    n_count  = '0;
                    n_status = STATUS_INVALID;
                    n_state  = S_OUT;
                end else if (r_idx == IDX_E2) begin
                    n_state = S_SELECT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_START;
                end
            end
            S_SELECT: begin
                n_cur    = s1_later ? r_dates[IDX_S1] : r_dates[IDX_S2];
                n_cur400 = s1_later ? r_r400[IDX_S1] : r_r400[IDX_S2];
                n_end    = e1_earlier ? r_dates[IDX_E1] : r_dates[IDX_E2];
                n_count  = '0;
                n_status = STATUS_OK;
                n_state  = (n_end > n_cur) ? S_WALK : S_OUT;
            end
            S_WALK: begin
                if (r_cur == r_end) begin
                    n_state = S_OUT;
                end else if (r_count == COUNT_MAX) begin
                    n_status = STATUS_SAT;
                    n_state  = S_OUT;
                end else begin
                    n_cur    = step_next;
                    n_cur400 = step_next_r400;
                    n_count  = r_count + COUNT_BITS'(1);
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_idx    <= n_idx;
        r_cur    <= n_cur;
        r_cur400 <= n_cur400;
        r_end    <= n_end;
        r_count  <= n_count;
        r_status <= n_status;
    end

    // Input item capture.
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_dates[IDX_S1] <= '{i_first_start_year, i_first_start_month, i_first_start_day};
            r_dates[IDX_E1] <= '{i_first_end_year, i_first_end_month, i_first_end_day};
            r_dates[IDX_S2] <= '{i_second_start_year, i_second_start_month,
                                 i_second_start_day};
            r_dates[IDX_E2] <= '{i_second_end_year, i_second_end_month, i_second_end_day};
        end
    end

    // Year modulo 400 of each date, kept for the start of the walk.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_r400[r_idx] <= mod_rem;
        end
    end

    assign count_wide     = 32'(r_count);
    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_overlap_days = count_wide[OUT_W-1:0];
    assign o_status       = r_status;

`ifndef SYNTHESIS
    // An invalid date always reports a zero count.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STATUS_INVALID) |-> (r_count == '0))
        else $error("invalid date item with nonzero count");

    // Saturation is reported only with the counter at its maximum.
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STATUS_SAT) |-> (r_count == COUNT_MAX))
        else $error("saturated status without full count");

    // The walk never passes the end date.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cur <= r_end))
        else $error("day walk went past the end date");

    // The year reduction is finished and in range whenever a date is checked.
    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (mod_rem < R400_W'(YEAR_CYCLE)) && $past(mod_done))
        else $error("year remainder out of range at date check");
`endif

endmodule

`default_nettype wire
